// File: rtl/bqlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqlp_pkg
// Shared types and constants of the biquad low-pass filter: register map,
// state format and the microcode program of the step sequencer.
// ----------------------------------------------------------------------------
package bqlp_pkg;

  // State word: signed, 40 bits
  localparam int ST_BITS   = 40;
  // Coefficient word: signed, 32 bits
  localparam int COEF_W    = 32;
  // Delay word splits into a signed high part and an unsigned low part
  localparam int SPLIT     = 20;

  // Configuration map
  localparam int NUM_REGS  = 5;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;

  localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic [COEF_W-1:0] B0_RESET = 32'h1000_0000;

  // Microcode fields
  typedef enum logic [1:0] {MUL_NONE, MUL_HI, MUL_LO} mul_e;
  typedef enum logic [2:0] {A_B0, A_B1, A_B2, A_A1, A_A2} asel_e;
  typedef enum logic [1:0] {D_D1, D_D2, D_W} dsel_e;
  typedef enum logic [1:0] {PACC_NONE, PACC_LOAD, PACC_ADD} pacc_e;
  typedef enum logic [2:0] {SACC_NONE, SACC_XS, SACC_SUB, SACC_ADD, SACC_CHECK} sacc_e;
  typedef enum logic [1:0] {DIV_NONE, DIV_INIT, DIV_STEP, DIV_PRIME} div_e;
  typedef enum logic [1:0] {JMP_NONE, JMP_FILT, JMP_DIV} cond_e;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    mul_e  mul;
    asel_e asel;
    dsel_e dsel;
    pacc_e pacc;
    sacc_e sacc;
    div_e  div;
    cond_e cond;
    upc_t  target;
    logic  done;
  } ucode_t;

  localparam upc_t UPC_START    = 5'd0;
  localparam upc_t UPC_DIV_LOOP = 5'd2;
  localparam upc_t UPC_FILTER   = 5'd4;

  function automatic ucode_t uw(mul_e m, asel_e a, dsel_e d, pacc_e p, sacc_e s,
                                div_e v, cond_e c, upc_t t, logic dn);
    ucode_t w;
    w.mul    = m;
    w.asel   = a;
    w.dsel   = d;
    w.pacc   = p;
    w.sacc   = s;
    w.div    = v;
    w.cond   = c;
    w.target = t;
    w.done   = dn;
    return w;
  endfunction

  // Program ROM: optional priming divide, then two feedback and three
  // feedforward products, each a high half, a low half and a rounding add.
  function automatic ucode_t ucode_rom(upc_t pc);
    ucode_t w;
    case (pc)
      // load scaled sample, skip priming in filter mode
      5'd0:  w = uw(MUL_NONE, A_B0, D_D1, PACC_NONE, SACC_XS,   DIV_NONE,  JMP_FILT,
                    UPC_FILTER, 1'b0);
      5'd1:  w = uw(MUL_NONE, A_B0, D_D1, PACC_NONE, SACC_NONE, DIV_INIT,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd2:  w = uw(MUL_NONE, A_B0, D_D1, PACC_NONE, SACC_NONE, DIV_STEP,  JMP_DIV,
                    UPC_DIV_LOOP, 1'b0);
      5'd3:  w = uw(MUL_NONE, A_B0, D_D1, PACC_NONE, SACC_NONE, DIV_PRIME, JMP_NONE,
                    UPC_START, 1'b0);
      // w0 = xs - a1*d1 - a2*d2
      5'd4:  w = uw(MUL_HI,   A_A1, D_D1, PACC_NONE, SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd5:  w = uw(MUL_LO,   A_A1, D_D1, PACC_LOAD, SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd6:  w = uw(MUL_NONE, A_A1, D_D1, PACC_ADD,  SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd7:  w = uw(MUL_HI,   A_A2, D_D2, PACC_NONE, SACC_SUB,  DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd8:  w = uw(MUL_LO,   A_A2, D_D2, PACC_LOAD, SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd9:  w = uw(MUL_NONE, A_A2, D_D2, PACC_ADD,  SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd10: w = uw(MUL_NONE, A_A2, D_D2, PACC_NONE, SACC_SUB,  DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd11: w = uw(MUL_NONE, A_B0, D_W,  PACC_NONE, SACC_CHECK, DIV_NONE, JMP_NONE,
                    UPC_START, 1'b0);
      // y = b0*w0 + b1*d1 + b2*d2
      5'd12: w = uw(MUL_HI,   A_B0, D_W,  PACC_NONE, SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd13: w = uw(MUL_LO,   A_B0, D_W,  PACC_LOAD, SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd14: w = uw(MUL_NONE, A_B0, D_W,  PACC_ADD,  SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd15: w = uw(MUL_HI,   A_B1, D_D1, PACC_NONE, SACC_ADD,  DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd16: w = uw(MUL_LO,   A_B1, D_D1, PACC_LOAD, SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd17: w = uw(MUL_NONE, A_B1, D_D1, PACC_ADD,  SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd18: w = uw(MUL_HI,   A_B2, D_D2, PACC_NONE, SACC_ADD,  DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd19: w = uw(MUL_LO,   A_B2, D_D2, PACC_LOAD, SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd20: w = uw(MUL_NONE, A_B2, D_D2, PACC_ADD,  SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      5'd21: w = uw(MUL_NONE, A_B2, D_D2, PACC_NONE, SACC_ADD,  DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b0);
      // round, saturate, emit and shift the delay line
      5'd22: w = uw(MUL_NONE, A_B0, D_D1, PACC_NONE, SACC_NONE, DIV_NONE,  JMP_NONE,
                    UPC_START, 1'b1);
      default: begin
        w = uw(MUL_NONE, A_B0, D_D1, PACC_NONE, SACC_NONE, DIV_NONE, JMP_NONE,
               UPC_START, 1'b1);
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bqlp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqlp_in_if
// Sample channel: valid/ready handshake with mode bit and signed sample.
// ----------------------------------------------------------------------------
interface bqlp_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output func, output sample_in, input ready);
  modport sink   (input valid, input func, input sample_in, output ready);
endinterface
`default_nettype wire

// File: rtl/bqlp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqlp_out_if
// Result channel: valid/ready handshake with filtered sample and fault bit.
// ----------------------------------------------------------------------------
interface bqlp_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered_out;
  logic                           fault_flag;

  modport source (output valid, output filtered_out, output fault_flag, input ready);
  modport sink   (input valid, input filtered_out, input fault_flag, output ready);
endinterface
`default_nettype wire

// File: rtl/biquad_lowpass_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_lowpass_filter
// Second-order IIR section, direct form II, fixed point. A microcoded
// sequencer steps one shared 32x21 multiplier through the five products.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                    Payload
//  in_i      in   valid/ready                  func, sample_in
//  out_o     out  valid/ready, output register filtered_out, fault_flag
//  apb       in   psel/penable/pwrite, pready=1 paddr, pwdata, prdata
//
//  Filter item: 20 microcode steps from accept to result.
//  Prime item: adds 2 + SAMPLE_WIDTH+STATE_FRACTION+COEF_FRACTION steps
//  for the bit-serial divide (62 steps at default settings).
//  One item at a time; in_i.ready is high whenever the sequencer is idle,
//  including while a result waits in the output register.
//  The last step holds while the output register is still full.
//  Reset clears the delays and loads the coefficient reset values.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter
  import bqlp_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRACTION  = 28,
  parameter int STATE_FRACTION = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bqlp_in_if.sink            in_i,
  bqlp_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int P_W   = COEF_W + ST_BITS;              // full product
  localparam int PR_W  = COEF_W + SPLIT + 1;            // partial product
  localparam int R_W   = P_W - COEF_FRACTION;           // rounded product
  localparam int S_W   = (R_W + 2 > SW + STATE_FRACTION + 1) ?
                         R_W + 2 : SW + STATE_FRACTION + 1;
  localparam int YW    = S_W + 1 - STATE_FRACTION;
  localparam int XW    = (SW + STATE_FRACTION > ST_BITS) ? SW + STATE_FRACTION : ST_BITS + 1;
  localparam int NB    = SW + STATE_FRACTION + COEF_FRACTION;
  localparam int CNT_W = $clog2(NB);
  localparam int DV_W  = COEF_W + 1;                    // |b0+b1+b2|
  localparam int Q_W   = ST_BITS - 1;

  localparam logic signed [P_W-1:0]     PROD_RND = P_W'(1) <<< (COEF_FRACTION - 1);
  localparam logic signed [S_W:0]       Y_RND    = (S_W + 1)'(1) <<< (STATE_FRACTION - 1);
  localparam logic signed [ST_BITS-1:0] ST_MAX   = {1'b0, {(ST_BITS - 1){1'b1}}};
  localparam logic signed [ST_BITS-1:0] ST_MIN   = {1'b1, {(ST_BITS - 1){1'b0}}};
  localparam logic signed [SW-1:0]      Y_MAX    = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0]      Y_MIN    = {1'b1, {(SW - 1){1'b0}}};

  // Configuration registers
  logic signed [COEF_W-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     cfg_wr;

  // Sequencer
  logic   busy_q;
  upc_t   upc_q;
  ucode_t uw_cur;
  logic   in_acc, out_free, stall, jump;

  // Datapath
  logic signed [SW-1:0]       x_q;
  logic                       func_q;
  logic signed [ST_BITS-1:0]  d1_q, d2_q, w_q;
  logic                       fault_q;
  logic signed [PR_W-1:0]     prod_q, prod_d;
  logic signed [P_W-1:0]      pacc_q;
  logic signed [S_W-1:0]      sacc_q;
  logic signed [COEF_W-1:0]   a_op;
  logic signed [ST_BITS-1:0]  d_op;
  logic signed [SPLIT:0]      m_op;
  logic signed [R_W-1:0]      rprod;
  logic signed [XW-1:0]       xe;
  logic signed [ST_BITS-1:0]  xs;
  logic                       w_ok;

  // Divider
  logic [DV_W-1:0]            rem_q, dvs_q, rem_d;
  logic [Q_W-1:0]             quo_q;
  logic                       qsat_q, neg_q, zsum_q;
  logic [SW-1:0]              num_q;
  logic [CNT_W-1:0]           cnt_q;
  logic signed [DV_W:0]       csum;
  logic [DV_W:0]              trial;
  logic                       ge;
  logic signed [ST_BITS-1:0]  prime_v;

  // Output
  logic signed [S_W:0]        ysum;
  logic signed [YW-1:0]       yr;
  logic signed [SW-1:0]       ysat;
  logic                       out_valid_q, out_fault_q;
  logic signed [SW-1:0]       out_y_q;

  // ---------------- APB configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= B0_RESET;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_B0:  b0_q <= pwdata;
        REG_B1:  b1_q <= pwdata;
        REG_B2:  b2_q <= pwdata;
        REG_A1:  a1_q <= pwdata;
        REG_A2:  a2_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_B0:  prdata = b0_q;
      REG_B1:  prdata = b1_q;
      REG_B2:  prdata = b2_q;
      REG_A1:  prdata = a1_q;
      REG_A2:  prdata = a2_q;
      default: prdata = '0;
    endcase
  end

  // ---------------- Sequencer ----------------
  assign uw_cur      = ucode_rom(upc_q);
  assign in_i.ready  = !busy_q;
  assign in_acc      = in_i.valid && !busy_q;
  assign out_free    = !out_valid_q || out_o.ready;
  assign stall       = uw_cur.done && !out_free;
  assign jump        = (uw_cur.cond == JMP_FILT && !func_q) ||
                       (uw_cur.cond == JMP_DIV && cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UPC_START;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
        upc_q  <= UPC_START;
      end else if (busy_q && !stall) begin
        if (uw_cur.done) begin
          busy_q <= 1'b0;
        end
        upc_q <= jump ? uw_cur.target : upc_q + 5'd1;
      end
      // result register: load at the last step, clear when taken
      if (busy_q && uw_cur.done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- Sample scaling ----------------
  assign xe = XW'(x_q) <<< STATE_FRACTION;
  assign xs = (&xe[XW-1:ST_BITS-1] || ~|xe[XW-1:ST_BITS-1]) ? xe[ST_BITS-1:0] :
              (xe[XW-1] ? ST_MIN : ST_MAX);

  // ---------------- Multiplier operands ----------------
  always_comb begin
    case (uw_cur.asel)
      A_B0:    a_op = b0_q;
      A_B1:    a_op = b1_q;
      A_B2:    a_op = b2_q;
      A_A1:    a_op = a1_q;
      A_A2:    a_op = a2_q;
      default: a_op = b0_q;
    endcase
  end

  always_comb begin
    case (uw_cur.dsel)
      D_D1:    d_op = d1_q;
      D_D2:    d_op = d2_q;
      D_W:     d_op = w_q;
      default: d_op = d1_q;
    endcase
  end

  // high half signed, low half unsigned
  assign m_op   = (uw_cur.mul == MUL_HI) ? {d_op[ST_BITS-1], d_op[ST_BITS-1:SPLIT]}
                                         : {1'b0, d_op[SPLIT-1:0]};
  assign prod_d = a_op * m_op;
  assign rprod  = pacc_q[P_W-1:COEF_FRACTION];

  // w0 fits the state range
  assign w_ok = &sacc_q[S_W-1:ST_BITS-1] || ~|sacc_q[S_W-1:ST_BITS-1];

  // ---------------- Priming divider ----------------
  assign csum  = (DV_W + 1)'(b0_q) + (DV_W + 1)'(b1_q) + (DV_W + 1)'(b2_q);
  assign trial = {rem_q, num_q[SW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  always_comb begin
    if (ge) begin
      rem_d = DV_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[DV_W-1:0];
    end
  end

  always_comb begin
    if (zsum_q) begin
      if (x_q == '0) begin
        prime_v = '0;
      end else begin
        prime_v = x_q[SW-1] ? ST_MIN : ST_MAX;
      end
    end else if (qsat_q) begin
      prime_v = neg_q ? ST_MIN : ST_MAX;
    end else begin
      prime_v = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    end
  end

  // ---------------- Output rounding ----------------
  assign ysum = (S_W + 1)'(sacc_q) + Y_RND;
  assign yr   = ysum[S_W:STATE_FRACTION];
  assign ysat = (&yr[YW-1:SW-1] || ~|yr[YW-1:SW-1]) ? yr[SW-1:0] :
                (yr[YW-1] ? Y_MIN : Y_MAX);

  // ---------------- Delay line ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (busy_q && !in_acc) begin
      if (uw_cur.div == DIV_PRIME) begin
        d1_q <= prime_v;
        d2_q <= prime_v;
      end else if (uw_cur.done && out_free) begin
        d2_q <= d1_q;
        d1_q <= w_q;
      end
    end
  end

  // ---------------- Datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= in_i.sample_in;
      func_q <= in_i.func;
    end else if (busy_q) begin
      if (uw_cur.mul != MUL_NONE) begin
        prod_q <= prod_d;
      end

      case (uw_cur.pacc)
        PACC_LOAD: pacc_q <= {prod_q[P_W-SPLIT-1:0], {SPLIT{1'b0}}};
        PACC_ADD:  pacc_q <= pacc_q + P_W'(prod_q) + PROD_RND;
        default:   ;
      endcase

      case (uw_cur.sacc)
        SACC_XS:  sacc_q <= S_W'(xs);
        SACC_SUB: sacc_q <= sacc_q - S_W'(rprod);
        SACC_ADD: sacc_q <= sacc_q + S_W'(rprod);
        SACC_CHECK: begin
          w_q     <= w_ok ? sacc_q[ST_BITS-1:0] : xs;
          fault_q <= !w_ok;
          sacc_q  <= '0;
        end
        default: ;
      endcase

      case (uw_cur.div)
        DIV_INIT: begin
          rem_q  <= '0;
          quo_q  <= '0;
          qsat_q <= 1'b0;
          cnt_q  <= CNT_W'(NB - 1);
          neg_q  <= x_q[SW-1] ^ csum[DV_W];
          zsum_q <= (csum == '0);
          dvs_q  <= csum[DV_W] ? DV_W'(-csum) : csum[DV_W-1:0];
          num_q  <= x_q[SW-1] ? SW'(-x_q) : x_q;
        end
        DIV_STEP: begin
          rem_q  <= rem_d;
          quo_q  <= {quo_q[Q_W-2:0], ge};
          qsat_q <= qsat_q | quo_q[Q_W-1];
          num_q  <= {num_q[SW-2:0], 1'b0};
          cnt_q  <= cnt_q - CNT_W'(1);
        end
        default: ;
      endcase

      if (uw_cur.done && out_free) begin
        out_y_q     <= ysat;
        out_fault_q <= fault_q;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.filtered_out = out_y_q;
  assign out_o.fault_flag   = out_fault_q;

endmodule
`default_nettype wire

// File: rtl/bqlp_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqlp_chk
// Port-level checks of the biquad filter, attached by bind.
// ----------------------------------------------------------------------------
module bqlp_chk #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] out_data,
  input wire logic                    out_fault,
  input wire logic                    pready
);

  // one item in flight: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("bqlp: input ready stayed high after accept");

  // a result appears only at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("bqlp: result without a busy sequencer");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_fault))
    else $error("bqlp: stalled result changed");

  // configuration port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("bqlp: pready low");

endmodule

bind biquad_lowpass_filter bqlp_chk #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bqlp_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.filtered_out),
  .out_fault (out_o.fault_flag),
  .pready    (pready)
);
`default_nettype wire
